>>> rtl/rbd_pkg.sv
// Shared types and constants for the RGB box downscaler.
// Used by rbd_ctrl, rbd_lane and rgb_box_downscaler; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

    localparam int PIX_W        = 8;   // bits per color channel
    localparam int NUM_LANES    = 3;   // red, green, blue
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int FACTOR_REG_W = 5;
    localparam int SIZE_REG_W   = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FACTOR = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } rbd_cfg_idx_t;

    // Position of the current input pixel inside its square and the frame.
    typedef struct packed {
        logic active;       // pixel lies inside a whole square
        logic seg_first;    // first column of the square
        logic seg_last;     // last column of the square
        logic band_first;   // first row of the square
        logic square_last;  // last pixel of the square
        logic frame_last;   // square is the last whole one of the frame
    } rbd_pix_ctl_t;

    // Load strobes for the lane registers.
    typedef struct packed {
        logic accept;
        logic s1_load;
        logic s2_load;
    } rbd_pipe_ctl_t;

endpackage

`default_nettype wire

>>> rtl/rbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents are undefined after reset.
`timescale 1ns / 1ps
`default_nettype none

module rbd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/rbd_ctrl.sv
// Configuration registers and raster position counters of the downscaler.
// Depends on rbd_pkg for the register indexes and the pixel control struct.
`timescale 1ns / 1ps
`default_nettype none

module rbd_ctrl #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_FACTOR = 16,
    localparam int FACT_W    = $clog2(MAX_FACTOR + 1),
    localparam int SUB_W     = $clog2(MAX_FACTOR),
    localparam int XW        = $clog2(MAX_WIDTH + 1),
    localparam int COL_W     = $clog2(MAX_WIDTH)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           accept,
    output rbd_pkg::rbd_pix_ctl_t               pix_ctl,
    output logic      [COL_W-1:0]               col_addr,
    output logic      [FACT_W-1:0]              eff_factor
);

    localparam int YW = rbd_pkg::SIZE_REG_W;

    logic [rbd_pkg::FACTOR_REG_W-1:0] factor_reg, factor_next;
    logic [rbd_pkg::SIZE_REG_W-1:0]   width_reg, width_next;
    logic [rbd_pkg::SIZE_REG_W-1:0]   height_reg, height_next;
    logic [XW-1:0]    in_x_reg, in_x_next;
    logic [YW-1:0]    in_y_reg, in_y_next;
    logic [SUB_W-1:0] sub_col_reg, sub_col_next;
    logic [SUB_W-1:0] sub_row_reg, sub_row_next;
    logic [COL_W-1:0] col_pos_reg, col_pos_next;
    logic             col_whole_reg, col_whole_next;
    logic             row_whole_reg, row_whole_next;

    logic [FACT_W-1:0] eff_f;
    logic [FACT_W-1:0] f_m1;
    logic [XW-1:0]     eff_w;
    logic [YW-1:0]     eff_h;
    logic [XW-1:0]     x_left;
    logic [YW-1:0]     y_left;
    logic              col_fits;
    logic              row_fits;
    logic              seg_first;
    logic              seg_last;
    logic              band_first;
    logic              band_last;
    logic              row_end;
    logic              frame_end;
    logic              restart;

    always_comb
    begin
        if (factor_reg == '0)
        begin
            eff_f = FACT_W'(1);
        end
        else if (int'(factor_reg) > MAX_FACTOR)
        begin
            eff_f = FACT_W'(MAX_FACTOR);
        end
        else
        begin
            eff_f = FACT_W'(factor_reg);
        end

        if (width_reg == '0)
        begin
            eff_w = XW'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            eff_w = XW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = XW'(width_reg);
        end

        eff_h = (height_reg == '0) ? YW'(1) : height_reg;
    end

    // Pixels left in the row and rows left in the frame, counting the current one.
    assign x_left   = eff_w - in_x_reg;
    assign y_left   = eff_h - in_y_reg;
    assign col_fits = int'(x_left) >= int'(eff_f);
    assign row_fits = int'(y_left) >= int'(eff_f);
    assign f_m1     = eff_f - FACT_W'(1);

    assign seg_first  = (sub_col_reg == '0);
    assign band_first = (sub_row_reg == '0);
    assign seg_last   = (FACT_W'(sub_col_reg) == f_m1);
    assign band_last  = (FACT_W'(sub_row_reg) == f_m1);
    assign row_end    = (in_x_reg == eff_w - XW'(1));
    assign frame_end  = row_end && (in_y_reg == eff_h - YW'(1));

    // The whole-square decision is made at the start of a square and held for the rest.
    always_comb
    begin
        pix_ctl.active      = (seg_first ? col_fits : col_whole_reg)
                              && (band_first ? row_fits : row_whole_reg);
        pix_ctl.seg_first   = seg_first;
        pix_ctl.seg_last    = seg_last;
        pix_ctl.band_first  = band_first;
        pix_ctl.square_last = seg_last && band_last;
        // At the last pixel of a square, it is the last of the frame when no more than
        // one square width of pixels and one square height of rows remain.
        pix_ctl.frame_last  = (int'(x_left) <= int'(eff_f)) && (int'(y_left) <= int'(eff_f));
    end

    always_comb
    begin
        factor_next    = factor_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        in_x_next      = in_x_reg;
        in_y_next      = in_y_reg;
        sub_col_next   = sub_col_reg;
        sub_row_next   = sub_row_reg;
        col_pos_next   = col_pos_reg;
        col_whole_next = col_whole_reg;
        row_whole_next = row_whole_reg;
        restart        = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                rbd_pkg::CFG_FACTOR:
                begin
                    factor_next = cfg_data[rbd_pkg::FACTOR_REG_W-1:0];
                    restart     = 1'b1;
                end
                rbd_pkg::CFG_WIDTH:
                begin
                    width_next = cfg_data;
                    restart    = 1'b1;
                end
                rbd_pkg::CFG_HEIGHT:
                begin
                    height_next = cfg_data;
                    restart     = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
        else if (accept)
        begin
            if (seg_first)
            begin
                col_whole_next = col_fits;
            end
            if (band_first)
            begin
                row_whole_next = row_fits;
            end

            if (row_end)
            begin
                in_x_next    = '0;
                sub_col_next = '0;
                col_pos_next = '0;
                in_y_next    = in_y_reg + YW'(1);
                sub_row_next = band_last ? '0 : sub_row_reg + SUB_W'(1);
                restart      = frame_end;
            end
            else
            begin
                in_x_next = in_x_reg + XW'(1);
                if (seg_last)
                begin
                    sub_col_next = '0;
                    col_pos_next = col_pos_reg + COL_W'(1);
                end
                else
                begin
                    sub_col_next = sub_col_reg + SUB_W'(1);
                end
            end
        end

        if (restart)
        begin
            in_x_next    = '0;
            in_y_next    = '0;
            sub_col_next = '0;
            sub_row_next = '0;
            col_pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg    <= rbd_pkg::FACTOR_REG_W'(1);
            width_reg     <= rbd_pkg::SIZE_REG_W'(1);
            height_reg    <= rbd_pkg::SIZE_REG_W'(1);
            in_x_reg      <= '0;
            in_y_reg      <= '0;
            sub_col_reg   <= '0;
            sub_row_reg   <= '0;
            col_pos_reg   <= '0;
            col_whole_reg <= 1'b0;
            row_whole_reg <= 1'b0;
        end
        else
        begin
            factor_reg    <= factor_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            in_x_reg      <= in_x_next;
            in_y_reg      <= in_y_next;
            sub_col_reg   <= sub_col_next;
            sub_row_reg   <= sub_row_next;
            col_pos_reg   <= col_pos_next;
            col_whole_reg <= col_whole_next;
            row_whole_reg <= row_whole_next;
        end
    end

    assign col_addr   = col_pos_reg;
    assign eff_factor = eff_f;

`ifndef SYNTHESIS
    a_sub_col_in_square: assert property (@(posedge clk) disable iff (!rst_n)
        int'(sub_col_reg) < int'(eff_f) && int'(sub_row_reg) < int'(eff_f))
        else $error("square position counter outside the current factor");
`endif

endmodule

`default_nettype wire

>>> rtl/rbd_lane.sv
// One color lane: row segment sum, band sum and the mean by reciprocal multiply.
// Depends on rbd_pkg for the control structs and the channel width.
`timescale 1ns / 1ps
`default_nettype none

module rbd_lane #(
    parameter int MAX_FACTOR = 16,
    localparam int LOG_F     = $clog2(MAX_FACTOR),
    localparam int SUM_W     = rbd_pkg::PIX_W + 2 * LOG_F,
    localparam int K         = SUM_W + 2 * LOG_F,
    localparam int RECIP_W   = K + 1
) (
    input  wire logic                       clk,
    input  wire logic [rbd_pkg::PIX_W-1:0]  pix,
    input  wire rbd_pkg::rbd_pix_ctl_t      pix_ctl,
    input  wire rbd_pkg::rbd_pipe_ctl_t     pipe_ctl,
    input  wire logic [SUM_W-1:0]           rd_sum,
    input  wire logic [RECIP_W-1:0]         recip,
    output logic      [SUM_W-1:0]           wr_sum,
    output logic      [rbd_pkg::PIX_W-1:0]  mean
);

    localparam int HSUM_W = rbd_pkg::PIX_W + LOG_F;
    localparam int PROD_W = SUM_W + RECIP_W;

    logic [HSUM_W-1:0] hacc_reg;
    logic [SUM_W-1:0]  s1_total_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [HSUM_W-1:0] seg;
    logic [SUM_W-1:0]  total;

    // Sum of this square's pixels in the current row, then of the whole band so far.
    assign seg   = (pix_ctl.seg_first ? '0 : hacc_reg) + HSUM_W'(pix);
    assign total = pix_ctl.band_first ? SUM_W'(seg) : rd_sum + SUM_W'(seg);

    always_ff @(posedge clk)
    begin
        if (pipe_ctl.accept && pix_ctl.active)
        begin
            hacc_reg <= seg;
        end
        if (pipe_ctl.s1_load)
        begin
            s1_total_reg <= total;
        end
        if (pipe_ctl.s2_load)
        begin
            s2_prod_reg <= PROD_W'(s1_total_reg) * PROD_W'(recip);
        end
    end

    assign wr_sum = total;
    // The reciprocal is rounded up far enough that this slice is the exact floor.
    assign mean   = s2_prod_reg[K +: rbd_pkg::PIX_W];

endmodule

`default_nettype wire

>>> rtl/rgb_box_downscaler.sv
// A square's result passes the s1, s2 and output registers on its way to the output.
// Throughput: one input pixel per cycle; at most one result per pixel, and the input
// stalls only while three results wait behind a stalled output.
// Reset clears position counters and the pipeline and sets factor, width and height to 1.
// The column sum store is not cleared: every entry is loaded before it is read in a frame.
// Each configuration write to a known register restarts the frame.
`timescale 1ns / 1ps
`default_nettype none

module rgb_box_downscaler #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_FACTOR = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [rbd_pkg::PIX_W-1:0]      red_in,
    input  wire logic [rbd_pkg::PIX_W-1:0]      green_in,
    input  wire logic [rbd_pkg::PIX_W-1:0]      blue_in,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [rbd_pkg::PIX_W-1:0]      red_mean,
    output logic      [rbd_pkg::PIX_W-1:0]      green_mean,
    output logic      [rbd_pkg::PIX_W-1:0]      blue_mean,
    output logic                                frame_last
);

    localparam int LOG_F   = $clog2(MAX_FACTOR);
    localparam int FACT_W  = $clog2(MAX_FACTOR + 1);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int SUM_W   = rbd_pkg::PIX_W + 2 * LOG_F;
    localparam int K       = SUM_W + 2 * LOG_F;
    localparam int RECIP_W = K + 1;
    localparam int NL      = rbd_pkg::NUM_LANES;
    localparam int WORD_W  = NL * SUM_W;

    rbd_pkg::rbd_pix_ctl_t  pix_ctl;
    rbd_pkg::rbd_pipe_ctl_t pipe_ctl;

    logic [COL_W-1:0]          col_addr;
    logic [FACT_W-1:0]         eff_factor;
    logic [RECIP_W-1:0]        recip_tab [MAX_FACTOR + 1];
    logic [RECIP_W-1:0]        recip_reg;
    logic [WORD_W-1:0]         ram_rd_data;
    logic [WORD_W-1:0]         ram_wr_data;
    logic                      ram_rd_en;
    logic                      ram_wr_en;
    logic [rbd_pkg::PIX_W-1:0] lane_pix  [NL];
    logic [SUM_W-1:0]          lane_wr   [NL];
    logic [rbd_pkg::PIX_W-1:0] lane_mean [NL];

    logic accept;
    logic emit;
    logic out_free;
    logic s2_free;
    logic s1_free;

    logic s1_valid_reg, s1_valid_next;
    logic s1_last_reg, s1_last_next;
    logic s2_valid_reg, s2_valid_next;
    logic s2_last_reg, s2_last_next;
    logic out_valid_reg, out_valid_next;
    logic out_last_reg, out_last_next;
    logic [rbd_pkg::PIX_W-1:0] out_red_reg;
    logic [rbd_pkg::PIX_W-1:0] out_green_reg;
    logic [rbd_pkg::PIX_W-1:0] out_blue_reg;

    rbd_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .pix_ctl    (pix_ctl),
        .col_addr   (col_addr),
        .eff_factor (eff_factor)
    );

    // Reciprocal of the square's area, rounded up, for each factor.
    for (genvar g = 0; g <= MAX_FACTOR; g++)
    begin : g_recip
        localparam longint unsigned AREA  = (g == 0) ? 64'd1 : longint'(g) * longint'(g);
        localparam longint unsigned RECIP = ((64'd1 << K) + AREA - 64'd1) / AREA;
        assign recip_tab[g] = RECIP_W'(RECIP);
    end

    always_ff @(posedge clk)
    begin
        recip_reg <= recip_tab[eff_factor];
    end

    // Pipeline flow: each stage moves on when the stage after it is free or draining.
    assign out_free = !out_valid_reg || out_ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;
    assign accept   = in_valid && s1_free;
    assign emit     = accept && pix_ctl.active && pix_ctl.square_last;

    assign pipe_ctl.accept  = accept;
    assign pipe_ctl.s1_load = emit;
    assign pipe_ctl.s2_load = s1_valid_reg && s2_free;

    // The band sum of a column is fetched at the start of its row segment and
    // written back with the last pixel of that segment.
    assign ram_rd_en = accept && pix_ctl.active && pix_ctl.seg_first && !pix_ctl.band_first;
    assign ram_wr_en = accept && pix_ctl.active && pix_ctl.seg_last;

    assign lane_pix[0] = red_in;
    assign lane_pix[1] = green_in;
    assign lane_pix[2] = blue_in;

    for (genvar l = 0; l < NL; l++)
    begin : g_lane
        localparam int SLOT = NL - 1 - l;

        rbd_lane #(
            .MAX_FACTOR (MAX_FACTOR)
        ) u_lane (
            .clk      (clk),
            .pix      (lane_pix[l]),
            .pix_ctl  (pix_ctl),
            .pipe_ctl (pipe_ctl),
            .rd_sum   (ram_rd_data[SLOT*SUM_W +: SUM_W]),
            .recip    (recip_reg),
            .wr_sum   (lane_wr[l]),
            .mean     (lane_mean[l])
        );

        assign ram_wr_data[SLOT*SUM_W +: SUM_W] = lane_wr[l];
    end

    rbd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_sums (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (col_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (col_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        s1_valid_next  = s1_free ? emit : s1_valid_reg;
        s1_last_next   = emit ? pix_ctl.frame_last : s1_last_reg;
        s2_valid_next  = s2_free ? s1_valid_reg : s2_valid_reg;
        s2_last_next   = pipe_ctl.s2_load ? s1_last_reg : s2_last_reg;
        out_valid_next = out_free ? s2_valid_reg : out_valid_reg;
        out_last_next  = (out_free && s2_valid_reg) ? s2_last_reg : out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_last_reg   <= s1_last_next;
            s2_valid_reg  <= s2_valid_next;
            s2_last_reg   <= s2_last_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Merge the three lanes into one output request.
    always_ff @(posedge clk)
    begin
        if (out_free && s2_valid_reg)
        begin
            out_red_reg   <= lane_mean[0];
            out_green_reg <= lane_mean[1];
            out_blue_reg  <= lane_mean[2];
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_mean   = out_red_reg;
    assign green_mean = out_green_reg;
    assign blue_mean  = out_blue_reg;
    assign frame_last = out_last_reg;

`ifndef SYNTHESIS
    a_no_fetch_single_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        ram_rd_en |-> (eff_factor != FACT_W'(1)))
        else $error("column sum fetched although every square is a single pixel");

    a_s1_held_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_free) |=> s1_valid_reg)
        else $error("pending result lost in the first stage");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled while the pipeline has room");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for rgb_box_downscaler: drives pixel frames under several
// register settings and compares every output pixel with an in-bench box-mean predictor.
// Depends on rtl/rbd_pkg.sv and rtl/rgb_box_downscaler.sv.
`timescale 1ns / 1ps

module testbench;

    import rbd_pkg::*;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_FACTOR = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } mean_pix_t;

    typedef struct {
        int unsigned red;
        int unsigned green;
        int unsigned blue;
    } chan_acc_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [PIX_W-1:0]      red_in;
    logic [PIX_W-1:0]      green_in;
    logic [PIX_W-1:0]      blue_in;
    logic                  out_valid;
    logic                  out_ready;
    logic [PIX_W-1:0]      red_mean;
    logic [PIX_W-1:0]      green_mean;
    logic [PIX_W-1:0]      blue_mean;
    logic                  frame_last;

    // Predictor copy of the registers and the frame position.
    logic [FACTOR_REG_W-1:0] shrink_reg;
    logic [SIZE_REG_W-1:0]   width_reg;
    logic [SIZE_REG_W-1:0]   height_reg;
    int unsigned col_idx, row_idx, sub_x, sub_y, pix_x, pix_y;
    chan_acc_t   column_acc [MAX_WIDTH];

    mean_pix_t expected_means [$];
    int        mismatches;
    int        cycle_count;
    bit        tx_gaps_on;
    bit        rx_gaps_on;
    int        hold_request;
    int        hold_left;
    int        stall_left;

    rgb_box_downscaler #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_mean   (red_mean),
        .green_mean (green_mean),
        .blue_mean  (blue_mean),
        .frame_last (frame_last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int unsigned eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic void restart_frame();
        col_idx = 0;
        row_idx = 0;
        sub_x   = 0;
        sub_y   = 0;
        pix_x   = 0;
        pix_y   = 0;
    endfunction

    // Accumulates one accepted pixel into its column sum and queues the mean
    // when the pixel closes a whole square.
    function automatic void downscale_pixel(input logic [PIX_W-1:0] r, g, b);
        int unsigned f, w, h, out_w, out_h, area;
        mean_pix_t   pix;
        f = (shrink_reg == 0) ? 1 : ((shrink_reg > MAX_FACTOR) ? MAX_FACTOR : shrink_reg);
        w = eff_width();
        h = eff_height();
        out_w = w / f;
        out_h = h / f;
        if (pix_x < out_w * f && pix_y < out_h * f)
        begin
            if (sub_x == 0 && sub_y == 0)
            begin
                column_acc[col_idx].red   = r;
                column_acc[col_idx].green = g;
                column_acc[col_idx].blue  = b;
            end
            else
            begin
                column_acc[col_idx].red   += r;
                column_acc[col_idx].green += g;
                column_acc[col_idx].blue  += b;
            end
            if (sub_x == f - 1 && sub_y == f - 1)
            begin
                area = f * f;
                pix.red   = PIX_W'(column_acc[col_idx].red / area);
                pix.green = PIX_W'(column_acc[col_idx].green / area);
                pix.blue  = PIX_W'(column_acc[col_idx].blue / area);
                pix.last  = (col_idx == out_w - 1) && (row_idx == out_h - 1);
                expected_means.push_back(pix);
            end
        end
        sub_x++;
        if (sub_x >= f)
        begin
            sub_x = 0;
            col_idx++;
        end
        pix_x++;
        if (pix_x >= w)
        begin
            pix_x   = 0;
            sub_x   = 0;
            col_idx = 0;
            sub_y++;
            if (sub_y >= f)
            begin
                sub_y = 0;
                row_idx++;
            end
            pix_y++;
            if (pix_y >= h)
                restart_frame();
        end
    endfunction

    // Channel value with extra weight on the extremes.
    function automatic logic [PIX_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_pixel(input logic [PIX_W-1:0] r, g, b);
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        red_in   = r;
        green_in = g;
        blue_in  = b;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        downscale_pixel(r, g, b);
        @(negedge clk);
    endtask

    task automatic send_random_pixels(input int count);
        for (int k = 0; k < count; k++)
            send_pixel(pick_level(), pick_level(), pick_level());
    endtask

    // Registers change only with the block idle: no request offered, every
    // expected pixel out, and a SETTLE_CYCLES wait for squares that yield nothing.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        in_valid = 1'b0;
        while (expected_means.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            CFG_FACTOR:
            begin
                shrink_reg = value[FACTOR_REG_W-1:0];
                restart_frame();
            end
            CFG_WIDTH:
            begin
                width_reg = value;
                restart_frame();
            end
            CFG_HEIGHT:
            begin
                height_reg = value;
                restart_frame();
            end
            default: ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_geometry(input int f, input int w, input int h);
        set_reg(CFG_FACTOR, CFG_DATA_W'(f));
        set_reg(CFG_WIDTH, CFG_DATA_W'(w));
        set_reg(CFG_HEIGHT, CFG_DATA_W'(h));
    endtask

    // Output side: random stalls, plus a long hold when a test asks for one.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else if (rx_gaps_on && $urandom_range(0, 6) == 0)
        begin
            out_ready = 1'b0;
            stall_left = $urandom_range(0, 10);
        end
        else
        begin
            out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        mean_pix_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_means.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: r=%0d g=%0d b=%0d last=%0b",
                             red_mean, green_mean, blue_mean, frame_last);
            end
            else
            begin
                want = expected_means.pop_front();
                if (red_mean !== want.red || green_mean !== want.green ||
                    blue_mean !== want.blue || frame_last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected r=%0d g=%0d b=%0d last=%0b,",
                                 want.red, want.green, want.blue, want.last,
                                 " got r=%0d g=%0d b=%0d last=%0b",
                                 red_mean, green_mean, blue_mean, frame_last);
                end
            end
        end
    end

    // Reset values give a one-pixel frame, so every pixel is its own last output.
    task automatic test_reset_defaults();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'hAA, 8'h55, 8'h0F);
    endtask

    // Zero in any register behaves as one.
    task automatic test_zero_registers();
        set_geometry(0, 0, 0);
        send_pixel(8'h55, 8'hAA, 8'hF0);
        send_pixel(8'h0F, 8'hF0, 8'h55);
    endtask

    task automatic test_partial_squares();
        // Column 4 and row 2 lie outside the last whole square.
        set_geometry(2, 5, 3);
        send_random_pixels(15);
        // A square larger than the image yields nothing at all.
        set_geometry(3, 2, 2);
        send_random_pixels(4);
    endtask

    task automatic test_restart_on_write();
        set_geometry(2, 2, 2);
        send_random_pixels(3);
        set_reg(CFG_FACTOR, 13'd2);
        send_random_pixels(2);
        // A write past the last register must not disturb the frame position.
        set_reg(CFG_SPARE_IDX, 13'h1FFF);
        send_random_pixels(2);
    endtask

    // Factor above the maximum saturates; red stays full, blue ramps so the
    // mean truncates. The extra row below the square is dropped.
    task automatic test_max_factor();
        set_geometry(31, 16, 17);
        for (int k = 0; k < 272; k++)
            send_pixel(8'd255, 8'd0, PIX_W'(k));
    endtask

    task automatic test_large_sizes();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        // An oversized width saturates at the line store depth; the row is cut
        // short by the next setting.
        set_geometry(1, 8191, 1);
        send_random_pixels(64);
        set_geometry(2, 3, 8191);
        send_random_pixels(12);
    endtask

    task automatic test_output_backpressure();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        set_geometry(1, 16, 16);
        hold_request = 80;
        send_random_pixels(40);
    endtask

    // Mostly whole frames with random content, some cut short by the next setting.
    task automatic test_random_frames();
        int sent, f, w, h, frame_pix, count;
        sent = 0;
        while (sent < 60)
        begin
            case ($urandom_range(0, 9))
                0:       f = 0;
                1:       f = $urandom_range(5, 31);
                default: f = $urandom_range(1, 4);
            endcase
            w = ($urandom_range(0, 12) == 0) ? 0 : $urandom_range(1, 16);
            h = ($urandom_range(0, 12) == 0) ? 0 : $urandom_range(1, 16);
            set_geometry(f, w, h);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            frame_pix = eff_width() * eff_height();
            if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, frame_pix);
            else
                count = frame_pix * $urandom_range(1, 2);
            send_random_pixels(count);
            sent += count;
        end
    endtask

    task automatic test_back_to_back();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        set_geometry(2, 8, 6);
        send_random_pixels(48);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_FACTOR;
        cfg_data     = '0;
        in_valid     = 1'b0;
        red_in       = '0;
        green_in     = '0;
        blue_in      = '0;
        out_ready    = 1'b0;
        tx_gaps_on   = 1'b0;
        rx_gaps_on   = 1'b0;
        hold_request = 0;
        hold_left    = 0;
        stall_left   = 0;
        mismatches   = 0;
        cycle_count  = 0;
        shrink_reg   = 1;
        width_reg    = 1;
        height_reg   = 1;
        restart_frame();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_zero_registers();
        test_partial_squares();
        test_restart_on_write();
        test_max_factor();
        test_large_sizes();
        test_output_backpressure();
        test_random_frames();
        test_back_to_back();

        in_valid = 1'b0;
        while (expected_means.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0 && expected_means.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
